/* sv/bcih_pkg.sv */
package bcih_pkg;

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PhInit    = 9'b000000001,
    PhVersion = 9'b000000010,
    PhIdle    = 9'b000000100,
    PhStart   = 9'b000001000,
    PhRestart = 9'b000010000,
    PhRead    = 9'b000100000,
    PhWrite   = 9'b001000000,
    PhPayload = 9'b010000000,
    PhErr     = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {
    OpNone     = 2'd0,
    OpWriteAck = 2'd1,
    OpRead     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActStart   = 3'd1,
    ActSend    = 3'd2,
    ActRecv    = 3'd3,
    ActEnd     = 3'd4,
    ActRestart = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdTick  = 2'd1,
    CmdClose = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  // Register indexes, taken from paddr[2]
  localparam logic RegStallPeriod   = 1'b0;
  localparam logic RegStopWaitLimit = 1'b1;

  localparam int unsigned AddrW = 3;

  localparam logic [15:0] StallPeriodRst   = 16'd100;
  localparam logic [17:0] StopWaitLimitRst = 18'd200000;

  localparam logic [7:0] ChI          = 8'h69;
  localparam logic [7:0] ChS          = 8'h53;
  localparam logic [7:0] ChR          = 8'h52;
  localparam logic [7:0] ChW          = 8'h57;
  localparam logic [7:0] ChP          = 8'h50;
  localparam logic [7:0] ChNack       = 8'h21;
  localparam logic [7:0] ChAck        = 8'h2E;
  localparam logic [7:0] ChErr        = 8'h78;
  localparam logic [7:0] ProtoVersion = 8'h01;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] host_byte;
    logic       wake_refused;
    logic       start_acked;
    logic       send_acked;
    logic       target_stretching;
    logic       final_ack_nack;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [2:0] bus_action;
    logic       end_after;
    logic       nack_first;
    logic [6:0] bus_address;
    logic       bus_read;
    logic [7:0] bus_data;
    logic       ready_res;
    logic       byte_refused;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    op_e         op;
    logic [6:0]  addr;
    logic [17:0] stop_wait;
    logic [15:0] stall;
  } state_t;

  typedef struct packed {
    logic [15:0] stall_period;
    logic [17:0] stop_wait_limit;
  } cfg_t;

endpackage

/* sv/bcih_if.sv */
interface bcih_in_if;
  import bcih_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcih_out_if;
  import bcih_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/byte_command_i2c_host_bridge_top.sv */
// Result: the result item for an accepted item is registered and shows on out_o in the next cycle.
// Throughput: one item per cycle; in_i stays ready while the result register
//   is empty or being drained, so the single result register sets the pace.
// Reset: rst_ni is asynchronous, active low; the parser returns to handshake
//   wait, counters clear and the registers take stall period 100 and stop
//   wait limit 200000.
module byte_command_i2c_host_bridge_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bcih_in_if.sink                   in_i,
  bcih_out_if.source                out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bcih_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bcih_pkg::*;

  // Parser, hold-off and deferred-op state
  state_t    state_d, state_q;
  // Result register; payload carries no reset
  out_item_t res_d, res_q;
  logic      res_valid_d, res_valid_q;
  cfg_t      cfg_q;
  logic      in_fire;
  logic      cfg_wr;
  logic      state_ready;

  // Config port: writes land in the access cycle, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_period    <= StallPeriodRst;
      cfg_q.stop_wait_limit <= StopWaitLimitRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegStallPeriod:   cfg_q.stall_period    <= pwdata[15:0];
        RegStopWaitLimit: cfg_q.stop_wait_limit <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegStallPeriod:   prdata = {16'd0, cfg_q.stall_period};
      RegStopWaitLimit: prdata = {14'd0, cfg_q.stop_wait_limit};
      default:          prdata = 32'd0;
    endcase
  end

  // Take a new item whenever the result register is free or drains this cycle
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // All decisions for one item: parser, stall counter, deferred ops
  bcih_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (in_i.data),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PhInit;
      state_q.op        <= OpNone;
      state_q.addr      <= '0;
      state_q.stop_wait <= '0;
      state_q.stall     <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the sink takes it
  assign res_valid_d = in_fire || (res_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  assign state_ready = (state_q.phase != PhErr) && (state_q.op == OpNone) &&
                       (state_q.stall == 16'd0);

`ifndef SYNTHESIS
  // The ready flag in each result matches the state it leaves behind
  a_ready_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_q.ready_res == state_ready)
    else $error("ready_res disagrees with stored state");

  // A refused byte drives no bus action and no reply
  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.byte_refused |-> res_q.bus_action == ActNone &&
    !res_q.reply_valid)
    else $error("refused byte produced activity");

  // Closing the link cancels the stall and restarts the handshake
  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.command == CmdClose |=>
    state_q.stall == 16'd0 && state_q.phase == PhInit)
    else $error("link close did not reset parser");
`endif

endmodule

/* sv/bcih_step.sv */
module bcih_step (
  input  bcih_pkg::state_t    cur_i,
  input  bcih_pkg::cfg_t      cfg_i,
  input  bcih_pkg::in_item_t  item_i,
  output bcih_pkg::state_t    nxt_o,
  output bcih_pkg::out_item_t res_o
);
  import bcih_pkg::*;

  logic [15:0] stall_load;
  logic        ready_now;
  logic        stretch;
  logic        waited;
  logic [7:0]  b;

  assign stall_load = (cfg_i.stall_period == 16'd0) ? 16'd1 : cfg_i.stall_period;
  assign ready_now  = (cur_i.phase != PhErr) && (cur_i.op == OpNone) &&
                      (cur_i.stall == 16'd0);
  assign stretch    = item_i.target_stretching;
  assign b          = item_i.host_byte;

  always_comb begin
    nxt_o  = cur_i;
    res_o  = '0;
    waited = 1'b0;
    unique case (cmd_e'(item_i.command))
      CmdByte: begin
        if (!ready_now) begin
          res_o.byte_refused = 1'b1;
        end else begin
          unique case (cur_i.phase)
            PhInit: begin
              nxt_o.phase = (b == ChI) ? PhVersion : PhErr;
            end
            PhVersion: begin
              res_o.reply_valid = 1'b1;
              if (b == ProtoVersion) begin
                res_o.reply_byte = ChAck;
                nxt_o.phase      = PhIdle;
              end else begin
                res_o.reply_byte = ChNack;
                nxt_o.phase      = PhErr;
              end
            end
            PhIdle: begin
              nxt_o.phase = (b == ChS) ? PhStart : PhErr;
            end
            PhStart, PhRestart: begin
              nxt_o.addr        = b[7:1];
              nxt_o.op          = OpNone;
              nxt_o.stall       = stall_load;
              res_o.reply_valid = 1'b1;
              if (item_i.wake_refused) begin
                res_o.reply_byte = ChNack;
                nxt_o.phase      = PhInit;
              end else begin
                res_o.bus_action = ActStart;
                res_o.bus_read   = b[0];
                if (item_i.start_acked) begin
                  res_o.reply_byte = ChAck;
                  nxt_o.phase      = b[0] ? PhRead : PhWrite;
                end else begin
                  res_o.end_after  = 1'b1;
                  res_o.reply_byte = ChNack;
                  nxt_o.phase      = PhInit;
                end
              end
            end
            PhRead, PhWrite: begin
              priority if (cur_i.phase == PhRead && b == ChR) begin
                nxt_o.stall = stall_load;
                if (stretch) begin
                  nxt_o.op = OpRead;
                end else begin
                  res_o.bus_action  = ActRecv;
                  res_o.bus_read    = 1'b1;
                  res_o.reply_valid = 1'b1;
                  res_o.reply_byte  = item_i.read_data;
                end
              end else if (cur_i.phase == PhWrite && b == ChW) begin
                nxt_o.phase = PhPayload;
              end else if (b == ChP || b == ChS) begin
                res_o.nack_first = (cur_i.phase == PhRead);
                res_o.bus_action = (b == ChP) ? ActEnd : ActRestart;
                nxt_o.phase      = (b == ChP) ? PhInit : PhRestart;
                nxt_o.stop_wait  = cfg_i.stop_wait_limit;
                nxt_o.stall      = stall_load;
              end else begin
                res_o.bus_action  = ActEnd;
                res_o.reply_valid = 1'b1;
                res_o.reply_byte  = ChErr;
                nxt_o.phase       = PhErr;
              end
            end
            PhPayload: begin
              nxt_o.phase      = PhWrite;
              nxt_o.stall      = stall_load;
              res_o.bus_action = ActSend;
              res_o.bus_data   = b;
              priority if (!item_i.send_acked) begin
                res_o.reply_valid = 1'b1;
                res_o.reply_byte  = ChNack;
              end else if (stretch) begin
                nxt_o.op = OpWriteAck;
              end else begin
                res_o.reply_valid = 1'b1;
                res_o.reply_byte  = ChAck;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CmdTick: begin
        if (cur_i.stall != 16'd0) begin
          nxt_o.stall = cur_i.stall - 16'd1;
          if (cur_i.stall == 16'd1) begin
            // Stall expiry: first drain the stop wait, then finish a held op
            if (cur_i.stop_wait != 18'd0) begin
              if (stretch) begin
                nxt_o.stop_wait = cur_i.stop_wait - 18'd1;
                nxt_o.stall     = stall_load;
                waited          = 1'b1;
              end else begin
                nxt_o.stop_wait = 18'd0;
              end
            end
            if (!waited && cur_i.op != OpNone) begin
              nxt_o.stall = stall_load;
              if (!stretch) begin
                nxt_o.op          = OpNone;
                res_o.reply_valid = 1'b1;
                if (cur_i.op == OpWriteAck) begin
                  if (item_i.final_ack_nack) begin
                    res_o.bus_action = ActEnd;
                    res_o.reply_byte = ChNack;
                    nxt_o.phase      = PhInit;
                  end else begin
                    res_o.reply_byte = ChAck;
                  end
                end else begin
                  res_o.bus_action = ActRecv;
                  res_o.bus_read   = 1'b1;
                  res_o.reply_byte = item_i.read_data;
                end
              end
            end
          end
        end
      end
      CmdClose: begin
        if (cur_i.phase == PhRead || cur_i.phase == PhWrite ||
            cur_i.phase == PhPayload) begin
          res_o.bus_action = ActEnd;
        end
        nxt_o.phase = PhInit;
        nxt_o.stall = 16'd0;
      end
      default: begin
      end
    endcase
    res_o.bus_address = nxt_o.addr;
    res_o.ready_res   = (nxt_o.phase != PhErr) && (nxt_o.op == OpNone) &&
                        (nxt_o.stall == 16'd0);
  end

endmodule
